/* sv/sxf_pkg.sv */
// Shared types and constants for the sprite XOR framebuffer.
// No dependencies; imported by the core and the checker.
`timescale 1ns / 1ps

package sxf_pkg;

  // Command codes carried in the cmd field of an input transfer.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int unsigned SPRITE_BITS = 8;

  localparam logic [31:0] LIT_COLOR    = 32'h00FF_FFFF;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  sprite_row;
    logic [10:0] pixel_index;
  } sxf_in_t;

  typedef struct packed {
    logic        collision;
    logic [31:0] pixel_argb;
  } sxf_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_CALC,
    S_READ,
    S_MODIFY,
    S_DONE
  } sxf_state_e;

endpackage

/* sv/sprite_xor_framebuffer_core.sv */
// Top level of the sprite XOR framebuffer: sequencer, address unit and output register.
// Depends on sxf_pkg and instantiates sxf_ram for the pixel store.
`timescale 1ns / 1ps

// The framebuffer keeps SCREEN_WIDTH*SCREEN_HEIGHT one-bit pixels in a RAM of
// 8-pixel words, leftmost pixel in the most significant bit. A single RAM port
// pair under a small sequencer does all the work, and the block takes one
// transfer at a time (in_stall_o is high while it works). A draw computes the
// linear start index x_pos + y_pos*SCREEN_WIDTH once, then does a read-modify-
// write on each of the two words the eight sprite pixels can touch. A read
// uses one read. A clear sweeps the RAM one word per cycle. After reset the
// same sweep runs once before the first input transfer is taken. Pixels past
// the right edge spill into the next row; pixels beyond the store are left
// alone and never collide. A finished result sits in an output register, so
// the next input transfer is taken while that result still waits for the
// consumer. The product of SCREEN_WIDTH and SCREEN_HEIGHT must be a multiple
// of eight.

module sprite_xor_framebuffer_core #(
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sxf_pkg::sxf_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sxf_pkg::sxf_out_t out_data_o
);

  import sxf_pkg::*;

  localparam int unsigned PIXEL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned WORDS       = PIXEL_COUNT / SPRITE_BITS;
  localparam int unsigned WA          = $clog2(WORDS);
  // Largest start index is 255 + 255*SCREEN_WIDTH.
  localparam int unsigned BASE_W      = $clog2(255 * SCREEN_WIDTH + 256);
  // Word index of either touched word, one extra bit for the second word.
  localparam int unsigned CW          = BASE_W - 3 + 1;

  sxf_state_e state_q, state_d;

  sxf_in_t          item_q, item_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic             part_q, part_d;
  logic             hit_q, hit_d;
  logic [WA-1:0]    clr_q, clr_d;
  logic             init_q, init_d;
  logic             out_valid_q, out_valid_d;
  sxf_out_t         out_q, out_d;

  logic             ram_we;
  logic [WA-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [WA-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  logic             in_fire;
  logic             out_free;
  logic             clr_last;
  logic [CW-1:0]    word_cur;
  logic             word_ok;
  logic [7:0]       pat;
  logic [15:0]      mask16;
  logic [7:0]       mask;
  logic             is_draw;
  logic             is_read;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign clr_last = (clr_q == WA'(WORDS - 1));
  assign is_draw  = (item_q.cmd == CMD_DRAW);
  assign is_read  = (item_q.cmd == CMD_READ);

  // Word touched in this pass and the pixel mask that lands in it. A read
  // uses a single-pixel pattern in place of the sprite row.
  assign word_cur = CW'(base_q[BASE_W-1:3]) + CW'(part_q);
  assign word_ok  = (32'(word_cur) < 32'(WORDS));
  assign pat      = is_read ? 8'h80 : item_q.sprite_row;
  assign mask16   = {pat, 8'h00} >> base_q[2:0];
  assign mask     = part_q ? mask16[7:0] : mask16[15:8];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.cmd == CMD_CLEAR) begin
            state_d = S_CLEAR;
          end else if (in_data_i.cmd == CMD_DRAW || in_data_i.cmd == CMD_READ) begin
            state_d = S_CALC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        if (clr_last) begin
          state_d = init_q ? S_IDLE : S_DONE;
        end
      end
      S_CALC:   state_d = S_READ;
      S_READ:   state_d = S_MODIFY;
      S_MODIFY: begin
        state_d = (is_draw && !part_q) ? S_READ : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM controls for each state.
  always_comb begin
    item_d      = item_q;
    base_d      = base_q;
    part_d      = part_q;
    hit_d       = hit_q;
    clr_d       = clr_q;
    init_d      = init_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = word_cur[WA-1:0];
    ram_wdata   = ram_rdata ^ mask;
    ram_raddr   = word_cur[WA-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d = in_data_i;
          clr_d  = '0;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + WA'(1);
        hit_d     = 1'b0;
        if (clr_last) begin
          init_d = 1'b0;
        end
      end
      S_CALC: begin
        part_d = 1'b0;
        hit_d  = 1'b0;
        if (is_read) begin
          base_d = BASE_W'(item_q.pixel_index);
        end else begin
          base_d = BASE_W'(item_q.x_pos)
                 + BASE_W'(item_q.y_pos) * BASE_W'(SCREEN_WIDTH);
        end
      end
      S_READ: begin
        // Read address is driven by default.
      end
      S_MODIFY: begin
        if (word_ok) begin
          hit_d  = hit_q || (|(ram_rdata & mask));
          ram_we = is_draw;
        end
        part_d = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.collision  = is_draw && hit_q;
          out_d.pixel_argb = is_read ? ((hit_q ? LIT_COLOR : 32'h0) | ALPHA_OPAQUE) : 32'h0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
      part_q      <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      part_q      <= part_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    base_q <= base_d;
    out_q  <= out_d;
  end

  sxf_ram #(
    .WIDTH(SPRITE_BITS),
    .DEPTH(WORDS)
  ) u_pixel_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/sxf_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sxf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/sxf_checker.sv */
// Port-level checker for the sprite XOR framebuffer, bound to the top level.
// Depends on sxf_pkg.
`timescale 1ns / 1ps

module sxf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input sxf_pkg::sxf_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sxf_pkg::sxf_out_t out_data_o
);

  import sxf_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer taken back to back");

  // Colors are only the three legal values, and a collision comes only with a zero color.
  a_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_argb == 32'h0)
                 || (!out_data_o.collision
                     && (out_data_o.pixel_argb == ALPHA_OPAQUE
                         || out_data_o.pixel_argb == (LIT_COLOR | ALPHA_OPAQUE))))
    else $error("illegal result payload");

endmodule

bind sprite_xor_framebuffer_core sxf_checker u_sxf_checker (.*);
